### hdl/lacb_pkg.sv
// Shared widths and constants for the look-at camera basis block.
// Used by lacb_isqrt, lacb_norm and look_at_camera_basis; no dependencies.
`timescale 1ns / 1ps

package lacb_pkg;

  // Port formats.
  localparam int unsigned IN_W   = 32;  // Q16.16 input component
  localparam int unsigned AX_W   = 16;  // Q1.15 axis component

  // Internal widths.
  localparam int unsigned D_W    = 33;  // position minus target
  localparam int unsigned P1_W   = 48;  // Q16.16 times Q1.15 product
  localparam int unsigned CR_W   = 49;  // first cross product component
  localparam int unsigned P2_W   = 32;  // Q1.15 times Q1.15 product
  localparam int unsigned Y_W    = 34;  // rounded second cross sum
  localparam int unsigned SC_W   = 30;  // scaled magnitude
  localparam int unsigned SS_W   = 62;  // sum of squared scaled magnitudes
  localparam int unsigned RT_W   = 31;  // square root of the sum
  localparam int unsigned DEN_W  = 32;  // divisor, twice the root
  localparam int unsigned NUM_W  = 47;  // dividend, scaled magnitude * 2^16 + root
  localparam int unsigned QT_W   = 17;  // quotient, at most 32768
  localparam int unsigned FRAC_W = 16;  // shift applied to the dividend

  // Q1.15 limits and rounding.
  localparam logic [AX_W-1:0] AX_MAX = 16'h7FFF;
  localparam logic [AX_W-1:0] AX_MIN = 16'h8000;
  localparam int unsigned     RND_SH = 15;

endpackage

### hdl/look_at_camera_basis.sv
// Top level of the look-at camera basis block.
// Depends on lacb_pkg and lacb_norm (which uses lacb_isqrt).
`timescale 1ns / 1ps

// The block turns a camera position, a target point and an up vector, all
// signed Q16.16, into the orthonormal basis of the look-at view, every
// component in signed Q1.15 with saturation.
// Input channel: in_valid_i / in_ready_o with the nine coordinate ports. An
// item is taken on a rising edge where both are high.
// Output channel: out_valid_o / out_ready_i with the three axes and the
// degenerate flag, which is set when position equals target or when the up
// vector is parallel to the view axis (that axis and those after it are zero).
// From acceptance to out_valid_o an item passes through one input register, two
// normalizers of 55 stages each (31 of them come from the bit-per-stage square
// root and 17 from the bit-per-stage divider), two stages for the first cross
// product, one for the second and the output register. One item is accepted
// every cycle while the output is not stalled.
// The whole pipeline advances together whenever the output register is empty
// or is being read, so a stall at the output holds every item in place and
// in_ready_o follows it; no item is lost or repeated.
// Reset clears every valid bit; the data registers are not reset.

module look_at_camera_basis (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lacb_pkg::IN_W-1:0]     pos_x_i,
  input  logic [lacb_pkg::IN_W-1:0]     pos_y_i,
  input  logic [lacb_pkg::IN_W-1:0]     pos_z_i,
  input  logic [lacb_pkg::IN_W-1:0]     tgt_x_i,
  input  logic [lacb_pkg::IN_W-1:0]     tgt_y_i,
  input  logic [lacb_pkg::IN_W-1:0]     tgt_z_i,
  input  logic [lacb_pkg::IN_W-1:0]     upv_x_i,
  input  logic [lacb_pkg::IN_W-1:0]     upv_y_i,
  input  logic [lacb_pkg::IN_W-1:0]     upv_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lacb_pkg::AX_W-1:0]     right_x_o,
  output logic [lacb_pkg::AX_W-1:0]     right_y_o,
  output logic [lacb_pkg::AX_W-1:0]     right_z_o,
  output logic [lacb_pkg::AX_W-1:0]     upward_x_o,
  output logic [lacb_pkg::AX_W-1:0]     upward_y_o,
  output logic [lacb_pkg::AX_W-1:0]     upward_z_o,
  output logic [lacb_pkg::AX_W-1:0]     back_x_o,
  output logic [lacb_pkg::AX_W-1:0]     back_y_o,
  output logic [lacb_pkg::AX_W-1:0]     back_z_o,
  output logic                          degenerate_o
);

  localparam int unsigned IW  = lacb_pkg::IN_W;
  localparam int unsigned AW  = lacb_pkg::AX_W;
  localparam int unsigned DW  = lacb_pkg::D_W;
  localparam int unsigned P1W = lacb_pkg::P1_W;
  localparam int unsigned CW  = lacb_pkg::CR_W;
  localparam int unsigned P2W = lacb_pkg::P2_W;
  localparam int unsigned YW  = lacb_pkg::Y_W;

  logic out_valid_q;
  logic en;

  // Every stage moves when the output register can take a new value.
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // Input stage: view direction from target to position, at full width.
  logic               v0_q;
  logic [2:0][DW-1:0] d_q;
  logic [2:0][IW-1:0] u_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q[0] <= DW'($signed(pos_x_i)) - DW'($signed(tgt_x_i));
      d_q[1] <= DW'($signed(pos_y_i)) - DW'($signed(tgt_y_i));
      d_q[2] <= DW'($signed(pos_z_i)) - DW'($signed(tgt_z_i));
      u_q    <= {upv_z_i, upv_y_i, upv_x_i};
    end
  end

  // Back axis.
  logic               vz;
  logic [2:0][AW-1:0] z;
  logic               zz;
  logic [3*IW-1:0]    upz;

  lacb_norm #(
    .W  (DW),
    .PW (3 * IW)
  ) u_norm_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v0_q),
    .comp_i (d_q),
    .pay_i  (u_q),
    .vld_o  (vz),
    .unit_o (z),
    .zero_o (zz),
    .pay_o  (upz)
  );

  // Up vector cross back: products, then differences.
  logic [2:0][IW-1:0]  uz;
  logic signed [P1W-1:0] pr1_q [6];
  logic                vp1_q;
  logic [2:0][AW-1:0]  zp1_q;
  logic                dp1_q;
  logic                vc_q;
  logic [2:0][CW-1:0]  cr_q;
  logic [2:0][AW-1:0]  zc_q;
  logic                dc_q;

  assign uz = upz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp1_q <= 1'b0;
      vc_q  <= 1'b0;
    end else if (en) begin
      vp1_q <= vz;
      vc_q  <= vp1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pr1_q[0] <= $signed(uz[1]) * $signed(z[2]);
      pr1_q[1] <= $signed(uz[2]) * $signed(z[1]);
      pr1_q[2] <= $signed(uz[2]) * $signed(z[0]);
      pr1_q[3] <= $signed(uz[0]) * $signed(z[2]);
      pr1_q[4] <= $signed(uz[0]) * $signed(z[1]);
      pr1_q[5] <= $signed(uz[1]) * $signed(z[0]);
      zp1_q    <= z;
      dp1_q    <= zz;

      cr_q[0] <= CW'(pr1_q[0]) - CW'(pr1_q[1]);
      cr_q[1] <= CW'(pr1_q[2]) - CW'(pr1_q[3]);
      cr_q[2] <= CW'(pr1_q[4]) - CW'(pr1_q[5]);
      zc_q    <= zp1_q;
      dc_q    <= dp1_q;
    end
  end

  // Right axis.
  logic               vx;
  logic [2:0][AW-1:0] x;
  logic               zx;
  logic [3*AW:0]      zpx;

  lacb_norm #(
    .W  (CW),
    .PW (3 * AW + 1)
  ) u_norm_right (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vc_q),
    .comp_i (cr_q),
    .pay_i  ({zc_q, dc_q}),
    .vld_o  (vx),
    .unit_o (x),
    .zero_o (zx),
    .pay_o  (zpx)
  );

  logic [2:0][AW-1:0] zx2;
  assign zx2 = zpx[3*AW:1];

  // Upward axis: back cross right, rounded to Q1.15.
  logic signed [P2W-1:0] pr2_q [6];
  logic                  vp2_q;
  logic [2:0][AW-1:0]    xp2_q;
  logic [2:0][AW-1:0]    zp2_q;
  logic                  dp2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp2_q <= 1'b0;
    end else if (en) begin
      vp2_q <= vx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pr2_q[0] <= $signed(zx2[1]) * $signed(x[2]);
      pr2_q[1] <= $signed(zx2[2]) * $signed(x[1]);
      pr2_q[2] <= $signed(zx2[2]) * $signed(x[0]);
      pr2_q[3] <= $signed(zx2[0]) * $signed(x[2]);
      pr2_q[4] <= $signed(zx2[0]) * $signed(x[1]);
      pr2_q[5] <= $signed(zx2[1]) * $signed(x[0]);
      xp2_q    <= x;
      zp2_q    <= zx2;
      dp2_q    <= zpx[0] | zx;
    end
  end

  logic [2:0][AW-1:0] y_d;

  always_comb begin
    logic signed [YW-1:0] v;
    logic signed [YW-1:0] sh;
    for (int i = 0; i < 3; i++) begin
      v  = YW'(pr2_q[2*i]) - YW'(pr2_q[2*i+1])
         + YW'($signed({1'b0, 1'b1, 14'b0}));
      sh = v >>> lacb_pkg::RND_SH;
      if (sh > $signed(YW'(32'sd32767))) begin
        y_d[i] = lacb_pkg::AX_MAX;
      end else if (sh < $signed(YW'(-32'sd32768))) begin
        y_d[i] = lacb_pkg::AX_MIN;
      end else begin
        y_d[i] = sh[AW-1:0];
      end
    end
  end

  // Output register.
  logic [2:0][AW-1:0] right_q;
  logic [2:0][AW-1:0] upward_q;
  logic [2:0][AW-1:0] back_q;
  logic               deg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vp2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      right_q  <= xp2_q;
      upward_q <= y_d;
      back_q   <= zp2_q;
      deg_q    <= dp2_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign right_x_o    = right_q[0];
  assign right_y_o    = right_q[1];
  assign right_z_o    = right_q[2];
  assign upward_x_o   = upward_q[0];
  assign upward_y_o   = upward_q[1];
  assign upward_z_o   = upward_q[2];
  assign back_x_o     = back_q[0];
  assign back_y_o     = back_q[1];
  assign back_z_o     = back_q[2];
  assign degenerate_o = deg_q;

endmodule

### hdl/lacb_isqrt.sv
// Pipelined floor square root, one result bit per register stage.
// Carries a side payload alongside; uses lacb_pkg for its default width.
`timescale 1ns / 1ps

module lacb_isqrt #(
  parameter int unsigned IW = lacb_pkg::SS_W,
  parameter int unsigned PW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  logic [IW-1:0]   rad_i,
  input  logic [PW-1:0]   pay_i,
  output logic            vld_o,
  output logic [IW/2-1:0] root_o,
  output logic [PW-1:0]   pay_o
);

  localparam int unsigned OW = IW / 2;
  localparam int unsigned RW = OW + 3;

  logic [OW-1:0] root_q [OW];
  logic [RW-1:0] rem_q  [OW];
  logic [IW-1:0] rad_q  [OW];
  logic [PW-1:0] pay_q  [OW];
  logic          vld_q  [OW];

  for (genvar k = 0; k < OW; k++) begin : g_stage
    logic [OW-1:0] r_c;
    logic [RW-1:0] e_c;
    logic [IW-1:0] x_c;
    logic [PW-1:0] p_c;
    logic          v_c;
    logic [RW-1:0] e2;
    logic [RW-1:0] trial;

    if (k == 0) begin : g_first
      assign r_c = '0;
      assign e_c = '0;
      assign x_c = rad_i;
      assign p_c = pay_i;
      assign v_c = vld_i;
    end else begin : g_next
      assign r_c = root_q[k-1];
      assign e_c = rem_q[k-1];
      assign x_c = rad_q[k-1];
      assign p_c = pay_q[k-1];
      assign v_c = vld_q[k-1];
    end

    // Bring down the next two radicand bits and try the next root bit.
    assign e2    = {e_c[RW-3:0], x_c[IW-1 -: 2]};
    assign trial = RW'({r_c, 2'b01});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_c;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (e2 >= trial) begin
          rem_q[k]  <= e2 - trial;
          root_q[k] <= {r_c[OW-2:0], 1'b1};
        end else begin
          rem_q[k]  <= e2;
          root_q[k] <= {r_c[OW-2:0], 1'b0};
        end
        rad_q[k] <= {x_c[IW-3:0], 2'b00};
        pay_q[k] <= p_c;
      end
    end
  end

  assign vld_o  = vld_q[OW-1];
  assign root_o = root_q[OW-1];
  assign pay_o  = pay_q[OW-1];

endmodule

### hdl/lacb_norm.sv
// Pipelined normalizer of a signed 3-vector to Q1.15 with a zero-length flag.
// Uses lacb_pkg constants and lacb_isqrt for the length.
`timescale 1ns / 1ps

module lacb_norm #(
  parameter int unsigned W  = lacb_pkg::D_W,
  parameter int unsigned PW = 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             vld_i,
  input  logic [2:0][W-1:0]                comp_i,
  input  logic [PW-1:0]                    pay_i,
  output logic                             vld_o,
  output logic [2:0][lacb_pkg::AX_W-1:0]   unit_o,
  output logic                             zero_o,
  output logic [PW-1:0]                    pay_o
);

  localparam int unsigned LW  = $clog2(W + 1);
  localparam int unsigned SC  = lacb_pkg::SC_W;
  localparam int unsigned QN  = lacb_pkg::QT_W;
  localparam int unsigned DW  = lacb_pkg::DEN_W;
  localparam int unsigned NW  = lacb_pkg::NUM_W;
  localparam int unsigned RTW = lacb_pkg::RT_W;
  localparam int unsigned AW  = lacb_pkg::AX_W;
  localparam int unsigned SPW = 1 + 3 + 3 * SC + PW;  // payload through the root
  localparam int unsigned DPW = 1 + 3 + PW;           // payload through the divider

  // Stage 1: magnitudes and signs.
  logic               v1_q;
  logic [2:0][W-1:0]  mag1_q;
  logic [2:0]         sgn1_q;
  logic [PW-1:0]      pay1_q;
  // Stage 2: largest magnitude.
  logic               v2_q;
  logic [W-1:0]       m2_q;
  logic [2:0][W-1:0]  mag2_q;
  logic [2:0]         sgn2_q;
  logic [PW-1:0]      pay2_q;
  // Stage 3: bit length of the largest magnitude.
  logic               v3_q;
  logic [LW-1:0]      l3_q;
  logic               zero3_q;
  logic [2:0][W-1:0]  mag3_q;
  logic [2:0]         sgn3_q;
  logic [PW-1:0]      pay3_q;
  // Stage 4: scaled magnitudes.
  logic               v4_q;
  logic               zero4_q;
  logic [2:0][SC-1:0] s4_q;
  logic [2:0]         sgn4_q;
  logic [PW-1:0]      pay4_q;
  // Stage 5: squares.
  logic               v5_q;
  logic               zero5_q;
  logic [2:0][2*SC-1:0] sq5_q;
  logic [2:0][SC-1:0] s5_q;
  logic [2:0]         sgn5_q;
  logic [PW-1:0]      pay5_q;
  // Stage 6: sum of squares.
  logic               v6_q;
  logic [lacb_pkg::SS_W-1:0] ss6_q;
  logic [SPW-1:0]     sp6_q;

  logic [2:0][W-1:0]  mag1_d;
  logic [W-1:0]       m2_d;
  logic [LW-1:0]      l3_d;
  logic [2:0][SC-1:0] s4_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag1_d[i] = comp_i[i][W-1] ? (W'(0) - comp_i[i]) : comp_i[i];
    end
  end

  always_comb begin
    m2_d = mag1_q[0];
    if (mag1_q[1] > m2_d) m2_d = mag1_q[1];
    if (mag1_q[2] > m2_d) m2_d = mag1_q[2];
  end

  always_comb begin
    l3_d = '0;
    for (int b = 0; b < W; b++) begin
      if (m2_q[b]) l3_d = LW'(b + 1);
    end
  end

  always_comb begin
    logic [W-1:0] sh;
    for (int i = 0; i < 3; i++) begin
      if (l3_q > LW'(SC)) begin
        sh = mag3_q[i] >> (l3_q - LW'(SC));
      end else begin
        sh = mag3_q[i] << (LW'(SC) - l3_q);
      end
      s4_d[i] = sh[SC-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag1_q <= mag1_d;
      for (int i = 0; i < 3; i++) sgn1_q[i] <= comp_i[i][W-1];
      pay1_q <= pay_i;

      m2_q   <= m2_d;
      mag2_q <= mag1_q;
      sgn2_q <= sgn1_q;
      pay2_q <= pay1_q;

      l3_q    <= l3_d;
      zero3_q <= (m2_q == '0);
      mag3_q  <= mag2_q;
      sgn3_q  <= sgn2_q;
      pay3_q  <= pay2_q;

      zero4_q <= zero3_q;
      s4_q    <= s4_d;
      sgn4_q  <= sgn3_q;
      pay4_q  <= pay3_q;

      zero5_q <= zero4_q;
      for (int i = 0; i < 3; i++) sq5_q[i] <= s4_q[i] * s4_q[i];
      s5_q    <= s4_q;
      sgn5_q  <= sgn4_q;
      pay5_q  <= pay4_q;

      ss6_q <= lacb_pkg::SS_W'(sq5_q[0]) + lacb_pkg::SS_W'(sq5_q[1])
             + lacb_pkg::SS_W'(sq5_q[2]);
      sp6_q <= {zero5_q, sgn5_q, s5_q, pay5_q};
    end
  end

  // Length: floor square root of the sum of squares.
  logic           vr;
  logic [RTW-1:0] root;
  logic [SPW-1:0] spr;

  lacb_isqrt #(
    .IW (lacb_pkg::SS_W),
    .PW (SPW)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .vld_i  (v6_q),
    .rad_i  (ss6_q),
    .pay_i  (sp6_q),
    .vld_o  (vr),
    .root_o (root),
    .pay_o  (spr)
  );

  logic [2:0][SC-1:0] sr;
  logic [DPW-1:0]     dpr;
  assign sr  = spr[3*SC+PW-1:PW];
  assign dpr = {spr[SPW-1 -: 4], spr[PW-1:0]};

  // Rounded quotient s * 2^15 / n by restoring long division, one bit a stage.
  logic [DW-1:0]        den_q  [QN];
  logic [2:0][DW-1:0]   rem_q  [QN];
  logic [2:0][QN-1:0]   nlo_q  [QN];
  logic [2:0][QN-1:0]   quo_q  [QN];
  logic [DPW-1:0]       dp_q   [QN];
  logic                 dv_q   [QN];

  for (genvar k = 0; k < QN; k++) begin : g_div
    logic [DW-1:0]      den_c;
    logic [2:0][DW-1:0] rem_c;
    logic [2:0][QN-1:0] nlo_c;
    logic [2:0][QN-1:0] quo_c;
    logic [DPW-1:0]     dp_c;
    logic               dv_c;

    if (k == 0) begin : g_first
      logic [2:0][NW-1:0] num;
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          num[i]   = NW'({sr[i], lacb_pkg::FRAC_W'(0)}) + NW'(root);
          rem_c[i] = DW'(num[i][NW-1:QN]);
          nlo_c[i] = num[i][QN-1:0];
        end
      end
      assign den_c = {root, 1'b0};
      assign quo_c = '0;
      assign dp_c  = dpr;
      assign dv_c  = vr;
    end else begin : g_next
      assign den_c = den_q[k-1];
      assign rem_c = rem_q[k-1];
      assign nlo_c = nlo_q[k-1];
      assign quo_c = quo_q[k-1];
      assign dp_c  = dp_q[k-1];
      assign dv_c  = dv_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else if (en_i) begin
        dv_q[k] <= dv_c;
      end
    end

    always_ff @(posedge clk_i) begin
      logic [DW:0] r2;
      if (en_i) begin
        for (int i = 0; i < 3; i++) begin
          r2 = {rem_c[i], nlo_c[i][QN-1]};
          if (r2 >= {1'b0, den_c}) begin
            rem_q[k][i] <= DW'(r2 - {1'b0, den_c});
            quo_q[k][i] <= {quo_c[i][QN-2:0], 1'b1};
          end else begin
            rem_q[k][i] <= DW'(r2);
            quo_q[k][i] <= {quo_c[i][QN-2:0], 1'b0};
          end
          nlo_q[k][i] <= {nlo_c[i][QN-2:0], 1'b0};
        end
        den_q[k] <= den_c;
        dp_q[k]  <= dp_c;
      end
    end
  end

  // Sign, saturation and zero-length forcing.
  logic [DPW-1:0]     dpl;
  logic               zl;
  logic [2:0]         sgnl;
  logic [2:0][AW-1:0] unit_d;
  assign dpl  = dp_q[QN-1];
  assign zl   = dpl[DPW-1];
  assign sgnl = dpl[DPW-2 -: 3];

  always_comb begin
    logic [QN-1:0] q;
    logic [QN-1:0] nq;
    for (int i = 0; i < 3; i++) begin
      q  = quo_q[QN-1][i];
      nq = QN'(0) - q;
      if (zl) begin
        unit_d[i] = '0;
      end else if (sgnl[i]) begin
        unit_d[i] = nq[AW-1:0];
      end else if (q[QN-1] || q[AW-1]) begin
        unit_d[i] = lacb_pkg::AX_MAX;
      end else begin
        unit_d[i] = q[AW-1:0];
      end
    end
  end

  logic               vo_q;
  logic [2:0][AW-1:0] unit_q;
  logic               zero_q;
  logic [PW-1:0]      payo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= dv_q[QN-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      unit_q <= unit_d;
      zero_q <= zl;
      payo_q <= dpl[PW-1:0];
    end
  end

  assign vld_o  = vo_q;
  assign unit_o = unit_q;
  assign zero_o = zero_q;
  assign pay_o  = payo_q;

endmodule
